// ===== rtl/cle_pkg.sv =====
package cle_pkg;

   localparam int RING_DEPTH = 128;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int PTR_W      = SLOT_W + 1;

   localparam logic [7:0] KEY_NUL  = 8'h00;
   localparam logic [7:0] KEY_EOF  = 8'h04;
   localparam logic [7:0] KEY_BS   = 8'h08;
   localparam logic [7:0] KEY_LF   = 8'h0A;
   localparam logic [7:0] KEY_CR   = 8'h0D;
   localparam logic [7:0] KEY_DUMP = 8'h10;
   localparam logic [7:0] KEY_KILL = 8'h15;

   localparam logic [1:0] ECHO_NONE  = 2'd0;
   localparam logic [1:0] ECHO_CHAR  = 2'd1;
   localparam logic [1:0] ECHO_ERASE = 2'd2;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic       action;
      logic [7:0] char_in;
      logic       first_of_read;
   } req_item_type;

   typedef struct packed {
      logic [1:0] echo_kind;
      logic [7:0] echo_char;
      logic [7:0] erase_count;
      logic       dump_request;
      logic       line_committed;
      logic       read_valid;
      logic [7:0] read_data;
      logic       read_eof;
      logic       read_line_end;
      logic       read_empty;
   } rsp_item_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   // saturate an erase count to one byte
   function automatic logic [7:0] sat_count(ptr_type n);
      if (PTR_W > 8 && n > ptr_type'(255)) begin
         return 8'hFF;
      end
      return 8'(n);
   endfunction

endpackage

// ===== rtl/cle_ram.sv =====
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cle_edit.sv =====
module cle_edit
   import cle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  req_item_type      item,
   input  logic [7:0]        ram_q,
   output logic [SLOT_W-1:0] ram_rd_addr,
   output ram_wr_type        ram_wr,
   output rsp_item_type      result
);

   ptr_type    read_ptr_ff, read_ptr_in;
   ptr_type    commit_ptr_ff, commit_ptr_in;
   ptr_type    edit_ptr_ff, edit_ptr_in;
   logic       byp_vld_ff, byp_vld_in;
   logic [7:0] byp_data_ff;
   logic [7:0] head;
   logic [7:0] ch_map;
   ptr_type    fill_len;
   ptr_type    line_len;
   ptr_type    ready_len;

   // the ring read is registered; forward a write that hit the head slot
   assign head      = byp_vld_ff ? byp_data_ff : ram_q;
   assign fill_len  = edit_ptr_ff - read_ptr_ff;
   assign line_len  = edit_ptr_ff - commit_ptr_ff;
   assign ready_len = commit_ptr_ff - read_ptr_ff;
   assign ch_map    = (item.char_in == KEY_CR) ? KEY_LF : item.char_in;

   always_comb begin
      result        = '0;
      ram_wr        = '0;
      read_ptr_in   = read_ptr_ff;
      commit_ptr_in = commit_ptr_ff;
      edit_ptr_in   = edit_ptr_ff;
      if (advance) begin
         if (!item.action) begin
            priority if (item.char_in == KEY_DUMP) begin
               result.dump_request = 1'b1;
            end else if (item.char_in == KEY_KILL) begin
               if (line_len != '0) begin
                  edit_ptr_in        = commit_ptr_ff;
                  result.echo_kind   = ECHO_ERASE;
                  result.erase_count = sat_count(line_len);
               end
            end else if (item.char_in == KEY_BS) begin
               if (line_len != '0) begin
                  edit_ptr_in        = edit_ptr_ff - ptr_type'(1);
                  result.echo_kind   = ECHO_ERASE;
                  result.erase_count = 8'd1;
               end
            end else if (item.char_in != KEY_NUL && !fill_len[PTR_W-1]) begin
               result.echo_kind = ECHO_CHAR;
               result.echo_char = ch_map;
               ram_wr.en        = 1'b1;
               ram_wr.addr      = edit_ptr_ff[SLOT_W-1:0];
               ram_wr.data      = ch_map;
               edit_ptr_in      = edit_ptr_ff + ptr_type'(1);
               // newline, end-of-file or the last free slot makes the line readable
               if (ch_map == KEY_LF || ch_map == KEY_EOF ||
                   fill_len == ptr_type'(RING_DEPTH - 1)) begin
                  commit_ptr_in         = edit_ptr_ff + ptr_type'(1);
                  result.line_committed = 1'b1;
               end
            end else begin
               // zero byte or full ring: drop without an echo
            end
         end else begin
            priority if (ready_len == '0) begin
               result.read_empty = 1'b1;
            end else if (head == KEY_EOF) begin
               result.read_eof = 1'b1;
               if (item.first_of_read) begin
                  read_ptr_in = read_ptr_ff + ptr_type'(1);
               end
            end else begin
               read_ptr_in          = read_ptr_ff + ptr_type'(1);
               result.read_valid    = 1'b1;
               result.read_data     = head;
               result.read_line_end = (head == KEY_LF);
            end
         end
      end
   end

   assign ram_rd_addr = read_ptr_in[SLOT_W-1:0];
   assign byp_vld_in  = ram_wr.en && (ram_wr.addr == ram_rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ptr_ff   <= '0;
         commit_ptr_ff <= '0;
         edit_ptr_ff   <= '0;
         byp_vld_ff    <= 1'b0;
      end else begin
         read_ptr_ff   <= read_ptr_in;
         commit_ptr_ff <= commit_ptr_in;
         edit_ptr_ff   <= edit_ptr_in;
         byp_vld_ff    <= byp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= ram_wr.data;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_len <= ptr_type'(RING_DEPTH))
      else $error("edit pointer runs more than a ring ahead of the reader");

   a_commit_inside: assert property (@(posedge clock) disable iff (reset)
      ready_len <= fill_len)
      else $error("commit pointer left the region between reader and edit");

   a_empty_holds: assert property (@(posedge clock) disable iff (reset)
      advance && item.action && result.read_empty |=> $stable(read_ptr_ff))
      else $error("read pointer moved on an empty read");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      $onehot0({result.read_valid, result.read_eof, result.read_empty,
                result.echo_kind != ECHO_NONE, result.dump_request}))
      else $error("more than one outcome in one result");

endmodule

// ===== rtl/console_line_editor.sv =====
// Line editor for a serial console: received bytes are edited in a 128-byte
// ring (backspace, kill line, dump request) and handed to a reader one byte
// at a time once a line is committed by newline, end-of-file or a full ring.
// One item is taken every clock cycle unless rsp_tready stalls the output;
// a result passes through the input and output registers before it is
// offered. The registered read of the ring memory is addressed by the
// reader's next pointer, so it adds no latency. An input register and an
// output register let a new request be taken while a result waits. The
// ring needs no clearing after reset: only committed slots are ever read.
module console_line_editor
   import cle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] char_in
   input  logic [1:0]  req_tuser,  // [0] action, [1] first_of_read
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] echo_char, [15:8] erase_count, [16] dump_request,
   // [17] line_committed, [18] read_valid, [26:19] read_data,
   // [27] read_eof, [28] read_line_end, [29] read_empty, [31:30] zero
   output logic [31:0] rsp_tdata,
   output logic [1:0]  rsp_tuser   // [1:0] echo_kind
);

   logic              in_vld_ff, in_vld_in;
   req_item_type      in_item_ff;
   logic              out_vld_ff, out_vld_in;
   rsp_item_type      out_item_ff;
   rsp_item_type      result;
   logic              advance;
   logic              req_take;
   ram_wr_type        ram_wr;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [7:0]        ram_q;

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.action        <= req_tuser[0];
         in_item_ff.char_in       <= req_tdata;
         in_item_ff.first_of_read <= req_tuser[1];
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   cle_edit u_edit (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (in_item_ff),
      .ram_q       (ram_q),
      .ram_rd_addr (ram_rd_addr),
      .ram_wr      (ram_wr),
      .result      (result)
   );

   cle_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_item_ff.echo_kind;
   assign rsp_tdata  = {2'b00,
                        out_item_ff.read_empty,
                        out_item_ff.read_line_end,
                        out_item_ff.read_eof,
                        out_item_ff.read_data,
                        out_item_ff.read_valid,
                        out_item_ff.line_committed,
                        out_item_ff.dump_request,
                        out_item_ff.erase_count,
                        out_item_ff.echo_char};

endmodule
